// ===== rtl/core/crqp_pkg.sv =====
`default_nettype none
package crqp_pkg;

  localparam int POS_W = 31;
  localparam int LEN_W = 28;
  localparam int WORD_W = 32;
  localparam int CODE_W = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_MAX = {POS_W{1'b1}};

  typedef enum logic [CODE_W-1:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } op_code_t;

  typedef enum logic [1:0] {
    OUT_MATCH    = 2'd0,
    OUT_BEFORE   = 2'd1,
    OUT_DELETION = 2'd2,
    OUT_PAST_END = 2'd3
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READ_START = 2'd0,
    CFG_TARGET_POS = 2'd1,
    CFG_LEFT_MODE  = 2'd2
  } cfg_index_t;

  // Operation held in the input register.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] op_word;
    logic              last_op;
  } op_stage_t;

  function automatic pos_t sat_add(pos_t a, pos_t b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_W] ? POS_MAX : s[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/crqp_if.sv =====
`default_nettype none
interface crqp_op_if import crqp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] op_word;
  logic              last_op;

  modport source (output valid, output op_word, output last_op, input ready);
  modport sink   (input valid, input op_word, input last_op, output ready);
endinterface

interface crqp_res_if import crqp_pkg::*;;
  logic       valid;
  logic       ready;
  pos_t       query_index;
  pos_t       ref_pos;
  logic [1:0] outcome;

  modport source (output valid, output query_index, output ref_pos, output outcome,
                  input ready);
  modport sink   (input valid, input query_index, input ref_pos, input outcome,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/crqp_in_reg.sv =====
`default_nettype none
module crqp_in_reg import crqp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  crqp_op_if.sink    op,
  input  wire logic  advance,
  output op_stage_t  stage
);

  assign op.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (op.valid && op.ready) begin
      stage.valid <= 1'b1;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
    if (op.valid && op.ready) begin
      stage.op_word <= op.op_word;
      stage.last_op <= op.last_op;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/crqp_walk.sv =====
`default_nettype none
module crqp_walk import crqp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire op_stage_t            stage,
  output logic                      advance,
  crqp_res_if.source                res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire pos_t                 cfg_data
);

  pos_t read_start;
  pos_t target_pos;
  logic left_mode;

  pos_t ref_cursor;
  pos_t query_cursor;
  pos_t last_match_end;
  logic decided;
  logic in_read;

  pos_t ref_cursor_next;
  pos_t query_cursor_next;
  pos_t last_match_end_next;
  logic decided_next;

  logic     emit;
  pos_t     res_query;
  pos_t     res_ref;
  outcome_t res_outcome;

  logic fire;

  assign advance = !res.valid || res.ready;
  assign fire    = stage.valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_start <= '0;
      target_pos <= '0;
      left_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READ_START: read_start <= cfg_data;
        CFG_TARGET_POS: target_pos <= cfg_data;
        CFG_LEFT_MODE:  left_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CODE_W-1:0] code;
    pos_t              len;
    pos_t              cur_ref;
    logic [POS_W:0]    reach;
    logic              hit;
    pos_t              sat_reach;
    pos_t              off;

    code      = stage.op_word[CODE_W-1:0];
    len       = {{(POS_W-LEN_W){1'b0}}, stage.op_word[WORD_W-1:CODE_W]};
    // first op of a read starts from the configured start
    cur_ref   = in_read ? ref_cursor : read_start;
    reach     = {1'b0, cur_ref} + {1'b0, len};
    hit       = reach > {1'b0, target_pos};
    sat_reach = reach[POS_W] ? POS_MAX : reach[POS_W-1:0];
    off       = (target_pos >= cur_ref) ? (target_pos - cur_ref) : '0;

    ref_cursor_next     = cur_ref;
    query_cursor_next   = query_cursor;
    last_match_end_next = last_match_end;
    decided_next        = decided;
    emit                = 1'b0;
    res_query           = query_cursor;
    res_ref             = cur_ref;
    res_outcome         = OUT_MATCH;

    if (!decided) begin
      case (code)
        OP_M, OP_EQ, OP_X: begin
          if (read_start > target_pos) begin
            emit         = 1'b1;
            decided_next = 1'b1;
            res_ref      = read_start;
            res_outcome  = OUT_BEFORE;
          end else if (hit) begin
            emit         = 1'b1;
            decided_next = 1'b1;
            res_query    = sat_add(query_cursor, off);
            res_ref      = target_pos;
            res_outcome  = OUT_MATCH;
          end else begin
            ref_cursor_next     = sat_reach;
            query_cursor_next   = sat_add(query_cursor, len);
            last_match_end_next = sat_add(query_cursor, len);
          end
        end
        OP_I, OP_S: begin
          query_cursor_next = sat_add(query_cursor, len);
        end
        OP_D, OP_N: begin
          if (hit) begin
            emit         = 1'b1;
            decided_next = 1'b1;
            res_ref      = left_mode ? cur_ref : sat_reach;
            res_outcome  = OUT_DELETION;
          end else begin
            ref_cursor_next = sat_reach;
          end
        end
        default: ;
      endcase
      // read ended with nothing found
      if (stage.last_op && !decided_next) begin
        emit        = 1'b1;
        res_query   = last_match_end_next;
        res_ref     = ref_cursor_next;
        res_outcome = OUT_PAST_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_read        <= 1'b0;
      decided        <= 1'b0;
      query_cursor   <= '0;
      last_match_end <= '0;
      ref_cursor     <= '0;
      res.valid      <= 1'b0;
    end else begin
      if (fire) begin
        if (stage.last_op) begin
          in_read        <= 1'b0;
          decided        <= 1'b0;
          query_cursor   <= '0;
          last_match_end <= '0;
          ref_cursor     <= '0;
        end else begin
          in_read        <= 1'b1;
          decided        <= decided_next;
          query_cursor   <= query_cursor_next;
          last_match_end <= last_match_end_next;
          ref_cursor     <= ref_cursor_next;
        end
      end
      if (fire && emit) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
    if (fire && emit) begin
      res.query_index <= res_query;
      res.ref_pos     <= res_ref;
      res.outcome     <= res_outcome;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && stage.last_op) |=> (!in_read && !decided))
    else $error("last op did not clear the read state");

  a_decided_in_read: assert property (@(posedge clk) disable iff (rst)
    decided |-> in_read)
    else $error("decided set outside a read");

  a_decided_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && decided) |-> !emit)
    else $error("result produced after the read was decided");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !fire)
    else $error("pending result would be overwritten");

endmodule
`default_nettype wire

// ===== rtl/core/cigar_ref_to_query_position.sv =====
// Path: accepted operations enter the input register; any result is registered on res.
// Throughput: one operation per cycle unless res stalls; the cursor update and result
// select sit in one stage behind the input register; the feedback loop closes there.
// Reset (synchronous, rst high): cursors, read state, config and valid flags clear.
`default_nettype none
module cigar_ref_to_query_position import crqp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  crqp_op_if.sink                   op,
  crqp_res_if.source                res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire pos_t                 cfg_data
);

  op_stage_t stage;
  logic      advance;

  crqp_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .advance (advance),
    .stage   (stage)
  );

  crqp_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .advance   (advance),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire

// ===== bench/tb_cigar_ref_to_query_position.sv =====
`default_nettype none
module tb_cigar_ref_to_query_position;
  import crqp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [CODE_W-1:0] CODE_UNUSED = 4'd5;
  localparam int LEN_MAX = (1 << LEN_W) - 1;

  typedef struct packed {
    pos_t     query_index;
    pos_t     ref_pos;
    outcome_t outcome;
  } mapping_t;

  class mapping_scoreboard;
    pos_t     read_start;
    pos_t     target_pos;
    logic     left_mode;
    pos_t     ref_cur;
    pos_t     query_cur;
    pos_t     match_end;
    bit       decided;
    bit       in_read;
    mapping_t pending[$];
    int       errors;

    function new();
      read_start = '0;
      target_pos = '0;
      left_mode  = 1'b0;
      errors     = 0;
      clear_read();
    endfunction

    function void clear_read();
      ref_cur   = '0;
      query_cur = '0;
      match_end = '0;
      decided   = 1'b0;
      in_read   = 1'b0;
    endfunction

    function pos_t clip_add(pos_t a, pos_t b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'(POS_MAX)) return POS_MAX;
      return pos_t'(s);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, pos_t data);
      case (idx)
        CFG_READ_START: read_start = data;
        CFG_TARGET_POS: target_pos = data;
        CFG_LEFT_MODE:  left_mode  = data[0];
        default: ;
      endcase
    endfunction

    // Walk one operation; return 1 when it produces a mapping.
    function bit map_op(logic [WORD_W-1:0] word, logic last, output mapping_t m);
      logic [LEN_W-1:0] len;
      longint           reach;
      pos_t             off;
      bit               hit;
      len = word[WORD_W-1:CODE_W];
      hit = 1'b0;
      m   = '0;
      if (!in_read) begin
        ref_cur = read_start;
        in_read = 1'b1;
      end
      if (!decided) begin
        reach = longint'(ref_cur) + longint'(len);
        case (word[CODE_W-1:0])
          OP_M, OP_EQ, OP_X: begin
            if (read_start > target_pos) begin
              m   = '{query_cur, read_start, OUT_BEFORE};
              hit = 1'b1;
            end else if (reach > longint'(target_pos)) begin
              off = (target_pos >= ref_cur) ? target_pos - ref_cur : '0;
              m   = '{clip_add(query_cur, off), target_pos, OUT_MATCH};
              hit = 1'b1;
            end else begin
              ref_cur   = clip_add(ref_cur, pos_t'(len));
              query_cur = clip_add(query_cur, pos_t'(len));
              match_end = query_cur;
            end
          end
          OP_I, OP_S: query_cur = clip_add(query_cur, pos_t'(len));
          OP_D, OP_N: begin
            if (reach > longint'(target_pos)) begin
              m   = '{query_cur, left_mode ? ref_cur : clip_add(ref_cur, pos_t'(len)),
                      OUT_DELETION};
              hit = 1'b1;
            end else begin
              ref_cur = clip_add(ref_cur, pos_t'(len));
            end
          end
          default: ;
        endcase
        decided = hit;
        if (last && !decided) begin
          m   = '{match_end, ref_cur, OUT_PAST_END};
          hit = 1'b1;
        end
      end
      if (last) clear_read();
      return hit;
    endfunction

    // Note an accepted operation and queue its mapping, if any.
    function void note_op(logic [WORD_W-1:0] word, logic last);
      mapping_t m;
      if (map_op(word, last, m)) pending.push_back(m);
    endfunction

    function void check_result(mapping_t got);
      mapping_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result q=%0d ref=%0d outcome=%0d", $time,
                 got.query_index, got.ref_pos, got.outcome);
        return;
      end
      want = pending.pop_front();
      if (got.query_index !== want.query_index) begin
        errors++;
        $display("%0t: query_index expected %0d actual %0d", $time,
                 want.query_index, got.query_index);
      end
      if (got.ref_pos !== want.ref_pos) begin
        errors++;
        $display("%0t: ref_pos expected %0d actual %0d", $time, want.ref_pos, got.ref_pos);
      end
      if (got.outcome !== want.outcome) begin
        errors++;
        $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, got.outcome);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  pos_t cfg_data;

  crqp_op_if  op_if ();
  crqp_res_if res_if ();

  cigar_ref_to_query_position i_dut (
    .clk       (clk),
    .rst       (rst),
    .op        (op_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mapping_scoreboard sb = new();
  int live_items = 0;
  int send_idle_pct = 34;
  int recv_idle_pct = 60;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("cigar_ref_to_query_position regression: fail");
    $finish;
  end

  // Result side: check each transaction, then pick the next ready.
  initial begin
    mapping_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        got = '{res_if.query_index, res_if.ref_pos, outcome_t'(res_if.outcome)};
        sb.check_result(got);
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [WORD_W-1:0] pack_op(logic [CODE_W-1:0] code, int len);
    return {LEN_W'(len), code};
  endfunction

  function automatic logic [WORD_W-1:0] random_op();
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    if ($urandom_range(99) < 12) return $urandom();
    case ($urandom_range(9))
      0, 1, 2: code = OP_M;
      3:       code = OP_I;
      4:       code = OP_D;
      5:       code = OP_N;
      6:       code = OP_S;
      7:       code = OP_EQ;
      default: code = OP_X;
    endcase
    len = ($urandom_range(19) == 0) ? LEN_W'($urandom()) : LEN_W'($urandom_range(40));
    return {len, code};
  endfunction

  task automatic send_op(logic [WORD_W-1:0] word, logic last);
    if (live_items < RANDOM_ITEMS / 3) begin
      send_idle_pct = 34;
      recv_idle_pct = 60;
    end else if (live_items < 2 * RANDOM_ITEMS / 3) begin
      send_idle_pct = 60;
      recv_idle_pct = 34;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      op_if.valid <= 1'b0;
      @(posedge clk);
    end
    op_if.valid   <= 1'b1;
    op_if.op_word <= word;
    op_if.last_op <= last;
    @(posedge clk);
    while (!op_if.ready) @(posedge clk);
    sb.note_op(word, last);
    live_items++;
  endtask

  // Hold off until every expected mapping is back and the pipe has settled.
  task automatic drain();
    op_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, pos_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_config(pos_t start, pos_t target, logic left);
    drain();
    cfg_write(CFG_READ_START, start);
    cfg_write(CFG_TARGET_POS, target);
    cfg_write(CFG_LEFT_MODE, pos_t'({$urandom(), left}));
    if ($urandom_range(3) == 0) cfg_write(CFG_SPARE, pos_t'($urandom()));
    cfg_we <= 1'b0;
  endtask

  task automatic send_read(int n_ops);
    for (int k = 0; k < n_ops; k++) send_op(random_op(), k == n_ops - 1);
  endtask

  initial begin
    pos_t   start;
    pos_t   target;
    longint near;
    int     n_reads;
    rst           <= 1'b1;
    op_if.valid   <= 1'b0;
    op_if.op_word <= '0;
    op_if.last_op <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_READ_START;
    cfg_data      <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    apply_config(pos_t'(100), pos_t'(110), 1'b0);
    send_op(pack_op(OP_M, 20), 1'b1);
    send_op(pack_op(OP_S, 5), 1'b0);
    send_op(pack_op(OP_I, 3), 1'b0);
    send_op(pack_op(OP_M, 5), 1'b0);
    send_op(pack_op(OP_D, 10), 1'b1);
    // exactly reaching the target does not decide: past end
    send_op(pack_op(OP_M, 10), 1'b1);
    send_op(pack_op(CODE_UNUSED, 3), 1'b0);
    send_op(pack_op(OP_N, 2), 1'b0);
    send_op(pack_op(OP_M, 20), 1'b1);

    apply_config(pos_t'(100), pos_t'(110), 1'b1);
    send_op(pack_op(OP_D, 20), 1'b0);
    send_op(pack_op(OP_M, 5), 1'b0);
    send_op(pack_op(OP_X, 5), 1'b1);

    // read starts after the target; deletion still wins when it comes first
    apply_config(POS_MAX, '0, 1'b0);
    send_op(pack_op(OP_EQ, 1), 1'b1);
    send_op(pack_op(OP_N, 1), 1'b0);
    send_op(pack_op(OP_M, 1), 1'b1);

    // saturate the query cursor and the deletion end
    apply_config(POS_MAX - pos_t'(5), POS_MAX, 1'b0);
    for (int k = 0; k < 9; k++) send_op(pack_op(OP_I, LEN_MAX), 1'b0);
    send_op(pack_op(OP_M, LEN_MAX), 1'b1);
    send_op(pack_op(OP_I, 1), 1'b0);
    send_op(pack_op(OP_D, LEN_MAX), 1'b1);
    send_op({WORD_W{1'b1}}, 1'b1);

    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      case ($urandom_range(5))
        0:       start = '0;
        1:       start = POS_MAX - pos_t'($urandom_range(300));
        2:       start = pos_t'($urandom());
        default: start = pos_t'($urandom_range(100000));
      endcase
      near = longint'(start) + longint'($urandom_range(150));
      case ($urandom_range(6))
        0:       target = start;
        1:       target = (start > pos_t'(20)) ? start - pos_t'($urandom_range(1, 20)) : '0;
        2:       target = POS_MAX;
        3:       target = pos_t'($urandom());
        default: target = (near > longint'(POS_MAX)) ? POS_MAX : pos_t'(near);
      endcase
      apply_config(start, target, logic'($urandom_range(1)));
      n_reads = $urandom_range(10, 30);
      for (int r = 0; r < n_reads; r++) begin
        if (live_items < RANDOM_ITEMS) send_read($urandom_range(1, 8));
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("cigar_ref_to_query_position regression: pass");
    end else begin
      $display("cigar_ref_to_query_position regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
